// ----- hdl/gti_pkg.sv -----
// Shared types, constants and register codes for the grid trilinear interpolator.
package gti_pkg;

  localparam int GRID_WORDS_DEF = 262144;
  localparam int MAX_SPAN_DEF   = 1024;

  localparam int SPAN_MAX_W = 13;
  localparam int QIDX_W     = 40;

  localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z    = 3'd2;
  localparam logic [2:0] REG_INV_SPACING = 3'd3;
  localparam logic [2:0] REG_SPAN_X      = 3'd4;
  localparam logic [2:0] REG_SPAN_Y      = 3'd5;
  localparam logic [2:0] REG_SPAN_Z      = 3'd6;
  localparam logic [2:0] REG_POINT_COUNT = 3'd7;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic [23:0]        inv_spacing;
    logic [10:0]        span_x;
    logic [10:0]        span_y;
    logic [10:0]        span_z;
    logic [18:0]        point_count;
  } cfg_t;

  typedef struct packed {
    logic                      is_query;
    logic                      near;
    logic [QIDX_W-1:0]         idx;
    logic [31:0]               value;
    logic [SPAN_MAX_W-1:0]     sx;
    logic [2*SPAN_MAX_W-1:0]   sxsy;
    logic [15:0]               fx;
    logic [15:0]               fy;
    logic [15:0]               fz;
  } entry_t;

endpackage

// ----- hdl/gti_queue.sv -----
// Two-entry queue between the front and back parts.
module gti_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  gti_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output gti_pkg::entry_t pop_entry,
  output logic            empty
);

  gti_pkg::entry_t q_r [2];
  logic            wp_r;
  logic            rp_r;
  logic [1:0]      cnt_r;
  logic            do_push;
  logic            do_pop;

  assign full      = (cnt_r == 2'd2);
  assign empty     = (cnt_r == 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ----- hdl/gti_front.sv -----
// Front part: accept items, scale query points, find corners and classify.
module gti_front #(
  parameter int MAX_SPAN = gti_pkg::MAX_SPAN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gti_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [17:0]        in_load_index,
  input  logic signed [31:0] in_load_value,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  output logic               q_push,
  output gti_pkg::entry_t    q_entry,
  input  logic               q_full
);

  localparam int SPW = $clog2(MAX_SPAN + 1);
  localparam int BW  = 26;
  localparam int WB  = 2 * SPW + BW + 2;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_SUB  = 3'd1;
  localparam logic [2:0] F_MUL  = 3'd2;
  localparam logic [2:0] F_NEAR = 3'd3;
  localparam logic [2:0] F_PROD = 3'd4;
  localparam logic [2:0] F_SUM  = 3'd5;
  localparam logic [2:0] F_PUSH = 3'd6;

  function automatic logic [SPW-1:0] eff_fn(logic [10:0] s);
    if (s == 11'd0) begin
      return SPW'(1);
    end
    if (32'(s) > MAX_SPAN) begin
      return SPW'(MAX_SPAN);
    end
    return SPW'(s);
  endfunction

  function automatic logic [SPW-1:0] near_fn(logic signed [BW-1:0] b, logic [15:0] f,
                                             logic neg, logic [SPW-1:0] sp);
    logic signed [BW+1:0] bw;
    logic signed [BW+1:0] n;
    logic signed [BW+1:0] spw;
    bw  = (BW+2)'(b);
    spw = $signed((BW+2)'(sp));
    n   = bw;
    if (f > 16'h8000 || (f == 16'h8000 && !neg)) begin
      n = bw + 1;
    end
    if (n >= spw) begin
      n = (bw >= spw) ? spw - 1 : bw;
    end
    if (n < 0) begin
      n = (bw + 1 < 0) ? (BW+2)'(0) : bw + 1;
    end
    return SPW'(n);
  endfunction

  logic [2:0]               state_r;
  logic signed [31:0]       p_r [3];
  logic signed [32:0]       d_r [3];
  logic signed [57:0]       m_r [3];
  logic signed [BW-1:0]     b_r [3];
  logic [15:0]              f_r [3];
  logic [SPW-1:0]           n_r [3];
  logic [SPW-1:0]           span [3];
  logic [2*SPW-1:0]         sxsy_r;
  logic signed [2*SPW+BW:0] pz_r;
  logic signed [SPW+BW:0]   py_r;
  logic [3*SPW-1:0]         nz_r;
  logic [2*SPW-1:0]         ny_r;
  logic signed [WB-1:0]     base;
  logic signed [WB-1:0]     hi;
  logic signed [WB-1:0]     sxw;
  logic signed [WB-1:0]     sxsyw;
  logic signed [WB-1:0]     pcw;
  logic [3*SPW-1:0]         nidx;
  logic                     in_range;
  gti_pkg::entry_t          entry_r;
  logic                     accept;

  assign span[0] = eff_fn(cfg.span_x);
  assign span[1] = eff_fn(cfg.span_y);
  assign span[2] = eff_fn(cfg.span_z);

  assign in_stall = (state_r != F_IDLE);
  assign accept   = in_valid && !in_stall;
  assign q_push   = (state_r == F_PUSH) && !q_full;
  assign q_entry  = entry_r;

  always_comb begin
    sxw      = WB'(span[0]);
    sxsyw    = WB'(sxsy_r);
    pcw      = WB'(cfg.point_count);
    base     = WB'(pz_r) + WB'(py_r) + WB'(b_r[0]);
    hi       = base + sxw + sxsyw + 1;
    in_range = (base >= 0) && (hi < pcw);
    nidx     = nz_r + (3*SPW)'(ny_r) + (3*SPW)'(n_r[0]);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_r[0] <= in_point_x;
      p_r[1] <= in_point_y;
      p_r[2] <= in_point_z;
    end
    if (state_r == F_SUB) begin
      d_r[0] <= {p_r[0][31], p_r[0]} - {cfg.origin_x[31], cfg.origin_x};
      d_r[1] <= {p_r[1][31], p_r[1]} - {cfg.origin_y[31], cfg.origin_y};
      d_r[2] <= {p_r[2][31], p_r[2]} - {cfg.origin_z[31], cfg.origin_z};
      sxsy_r <= span[0] * span[1];
    end
    if (state_r == F_MUL) begin
      for (int i = 0; i < 3; i++) begin
        m_r[i] <= d_r[i] * $signed({1'b0, cfg.inv_spacing});
      end
    end
    if (state_r == F_NEAR) begin
      for (int i = 0; i < 3; i++) begin
        b_r[i] <= m_r[i][57:32];
        f_r[i] <= m_r[i][31:16];
        n_r[i] <= near_fn(m_r[i][57:32], m_r[i][31:16], m_r[i][57], span[i]);
      end
    end
    if (state_r == F_PROD) begin
      pz_r <= $signed({1'b0, sxsy_r}) * b_r[2];
      py_r <= $signed({1'b0, span[0]}) * b_r[1];
      nz_r <= sxsy_r * n_r[2];
      ny_r <= span[0] * n_r[1];
    end
    if (accept && in_op == gti_pkg::OP_LOAD) begin
      entry_r.is_query <= 1'b0;
      entry_r.near     <= 1'b0;
      entry_r.idx      <= gti_pkg::QIDX_W'(in_load_index);
      entry_r.value    <= in_load_value;
    end
    if (state_r == F_SUM) begin
      entry_r.is_query <= 1'b1;
      entry_r.near     <= !in_range;
      entry_r.idx      <= in_range ? gti_pkg::QIDX_W'(base) : gti_pkg::QIDX_W'(nidx);
      entry_r.sx       <= gti_pkg::SPAN_MAX_W'(span[0]);
      entry_r.sxsy     <= (2*gti_pkg::SPAN_MAX_W)'(sxsy_r);
      entry_r.fx       <= f_r[0];
      entry_r.fy       <= f_r[1];
      entry_r.fz       <= f_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (accept) begin
            state_r <= (in_op == gti_pkg::OP_LOAD) ? F_PUSH : F_SUB;
          end
        end
        F_SUB:  state_r <= F_MUL;
        F_MUL:  state_r <= F_NEAR;
        F_NEAR: state_r <= F_PROD;
        F_PROD: state_r <= F_SUM;
        F_SUM:  state_r <= F_PUSH;
        F_PUSH: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/gti_back.sv -----
// Back part: grid memory, corner reads, shared lerp unit and result register.
module gti_back #(
  parameter int GRID_WORDS = gti_pkg::GRID_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  gti_pkg::entry_t    q_entry,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result_value,
  output logic               out_used_nearest
);

  localparam int AW = $clog2(GRID_WORDS);
  localparam int QW = gti_pkg::QIDX_W;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_READ = 3'd1;
  localparam logic [2:0] B_LM   = 3'd2;
  localparam logic [2:0] B_LA   = 3'd3;
  localparam logic [2:0] B_DONE = 3'd4;

  localparam logic signed [33:0] SAT_HI = 34'sh07FFFFFFF;
  localparam logic signed [33:0] SAT_LO = -34'sh080000000;

  logic [31:0]        mem [GRID_WORDS];
  logic [31:0]        mem_rd_r;
  logic [AW-1:0]      mem_addr;
  logic               mem_we;

  logic [2:0]         state_r;
  gti_pkg::entry_t    ent_r;
  logic [3:0]         cnt_r;
  logic [3:0]         nrd;
  logic               rd_pend_r;
  logic               rd_zero_r;
  logic [2:0]         rd_k_r;
  logic [QW-1:0]      rd_addr;
  logic               in_grid;
  logic signed [31:0] v_r [8];
  logic [2:0]         j_r;
  logic [2:0]         ia;
  logic [2:0]         ib;
  logic [15:0]        fsel;
  logic [16:0]        w;
  logic signed [48:0] pa_r;
  logic signed [48:0] pb_r;
  logic signed [49:0] sum;
  logic signed [33:0] q;
  logic signed [31:0] sat;
  logic               out_valid_r;
  logic signed [31:0] out_value_r;
  logic               out_near_r;
  logic               load_ok;

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_used_nearest = out_near_r;

  assign q_pop   = (state_r == B_IDLE) && !q_empty;
  assign load_ok = 64'(q_entry.idx) < 64'(GRID_WORDS);
  assign mem_we  = q_pop && !q_entry.is_query && load_ok;
  assign nrd     = ent_r.near ? 4'd1 : 4'd8;

  always_comb begin
    rd_addr = ent_r.idx + QW'(cnt_r[0]);
    if (cnt_r[1]) begin
      rd_addr = rd_addr + QW'(ent_r.sx);
    end
    if (cnt_r[2]) begin
      rd_addr = rd_addr + QW'(ent_r.sxsy);
    end
    in_grid  = 64'(rd_addr) < 64'(GRID_WORDS);
    mem_addr = (state_r == B_IDLE) ? q_entry.idx[AW-1:0] : rd_addr[AW-1:0];
  end

  always_comb begin
    case (j_r)
      3'd0: begin ia = 3'd0; ib = 3'd1; fsel = ent_r.fx; end
      3'd1: begin ia = 3'd2; ib = 3'd3; fsel = ent_r.fx; end
      3'd2: begin ia = 3'd4; ib = 3'd5; fsel = ent_r.fx; end
      3'd3: begin ia = 3'd6; ib = 3'd7; fsel = ent_r.fx; end
      3'd4: begin ia = 3'd0; ib = 3'd2; fsel = ent_r.fy; end
      3'd5: begin ia = 3'd4; ib = 3'd6; fsel = ent_r.fy; end
      3'd6: begin ia = 3'd0; ib = 3'd4; fsel = ent_r.fz; end
      default: begin ia = 3'd0; ib = 3'd0; fsel = 16'd0; end
    endcase
    w   = 17'h10000 - 17'(fsel);
    sum = 50'(pa_r) + 50'(pb_r) + 50'sd32768;
    q   = sum[49:16];
    if (q > SAT_HI) begin
      sat = 32'sh7FFFFFFF;
    end else if (q < SAT_LO) begin
      sat = 32'sh80000000;
    end else begin
      sat = q[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= q_entry.value;
    end
    mem_rd_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r <= q_entry;
    end
    if (rd_pend_r) begin
      v_r[rd_k_r] <= rd_zero_r ? 32'sd0 : $signed(mem_rd_r);
    end
    rd_zero_r <= !in_grid;
    rd_k_r    <= cnt_r[2:0];
    if (state_r == B_LM) begin
      pa_r <= v_r[ia] * $signed({1'b0, w});
      pb_r <= v_r[ib] * $signed({1'b0, 1'b0, fsel});
    end
    if (state_r == B_LA) begin
      v_r[ia] <= sat;
    end
    if (state_r == B_DONE && (!out_valid_r || !out_stall)) begin
      out_value_r <= v_r[0];
      out_near_r  <= ent_r.near;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cnt_r       <= 4'd0;
      j_r         <= 3'd0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == B_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          cnt_r     <= 4'd0;
          rd_pend_r <= 1'b0;
          if (q_pop && q_entry.is_query) begin
            state_r <= B_READ;
          end
        end
        B_READ: begin
          rd_pend_r <= (cnt_r < nrd);
          if (cnt_r < nrd) begin
            cnt_r <= cnt_r + 4'd1;
          end else begin
            j_r     <= 3'd0;
            state_r <= ent_r.near ? B_DONE : B_LM;
          end
        end
        B_LM: state_r <= B_LA;
        B_LA: begin
          if (j_r == 3'd6) begin
            state_r <= B_DONE;
          end else begin
            j_r     <= j_r + 3'd1;
            state_r <= B_LM;
          end
        end
        B_DONE: begin
          if (!out_valid_r || !out_stall) begin
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_READ) |-> (cnt_r <= 4'd8))
    else $error("read counter past eight corners");

  a_no_lerp_near: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_LM) |-> !ent_r.near)
    else $error("lerp started on a nearest-point query");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DONE && out_valid_r && out_stall) |=>
      (out_valid_r && $stable(out_value_r)))
    else $error("pending result overwritten");

endmodule

// ----- hdl/grid_trilinear_interpolator.sv -----
// Top level of the grid trilinear interpolator: register port, front, queue, back.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  op, load_index, load_value, point_x/y/z
//   out      output     out_valid/out_stall  result_value, used_nearest
//   cfg      input      psel/penable/pready  paddr, pwdata, prdata
//
// In the front a load goes to the push state; a query steps through sub, mul, near, prod,
// sum and push. The back writes a popped load, and reads a query's eight corners from the
// single-port grid memory, runs seven lerps in the shared lerp unit and posts the result;
// a nearest-point query reads one corner. Items are worked one at a time in each part.
// Reset is synchronous and clears control state; the grid memory is undefined until loaded.
// A stalled result holds the back part; the two-entry queue lets the front keep accepting.
module grid_trilinear_interpolator #(
  parameter int GRID_WORDS = gti_pkg::GRID_WORDS_DEF,
  parameter int MAX_SPAN   = gti_pkg::MAX_SPAN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [17:0]        in_load_index,
  input  logic signed [31:0] in_load_value,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result_value,
  output logic               out_used_nearest,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  gti_pkg::cfg_t   cfg_r;
  gti_pkg::entry_t push_entry;
  gti_pkg::entry_t pop_entry;
  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x    <= 32'sd0;
      cfg_r.origin_y    <= 32'sd0;
      cfg_r.origin_z    <= 32'sd0;
      cfg_r.inv_spacing <= 24'd65536;
      cfg_r.span_x      <= 11'd64;
      cfg_r.span_y      <= 11'd64;
      cfg_r.span_z      <= 11'd64;
      cfg_r.point_count <= 19'd0;
    end else if (wr_en) begin
      case (paddr[4:2])
        gti_pkg::REG_ORIGIN_X:    cfg_r.origin_x    <= pwdata;
        gti_pkg::REG_ORIGIN_Y:    cfg_r.origin_y    <= pwdata;
        gti_pkg::REG_ORIGIN_Z:    cfg_r.origin_z    <= pwdata;
        gti_pkg::REG_INV_SPACING: cfg_r.inv_spacing <= pwdata[23:0];
        gti_pkg::REG_SPAN_X:      cfg_r.span_x      <= pwdata[10:0];
        gti_pkg::REG_SPAN_Y:      cfg_r.span_y      <= pwdata[10:0];
        gti_pkg::REG_SPAN_Z:      cfg_r.span_z      <= pwdata[10:0];
        gti_pkg::REG_POINT_COUNT: cfg_r.point_count <= pwdata[18:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      gti_pkg::REG_ORIGIN_X:    prdata = cfg_r.origin_x;
      gti_pkg::REG_ORIGIN_Y:    prdata = cfg_r.origin_y;
      gti_pkg::REG_ORIGIN_Z:    prdata = cfg_r.origin_z;
      gti_pkg::REG_INV_SPACING: prdata = 32'(cfg_r.inv_spacing);
      gti_pkg::REG_SPAN_X:      prdata = 32'(cfg_r.span_x);
      gti_pkg::REG_SPAN_Y:      prdata = 32'(cfg_r.span_y);
      gti_pkg::REG_SPAN_Z:      prdata = 32'(cfg_r.span_z);
      gti_pkg::REG_POINT_COUNT: prdata = 32'(cfg_r.point_count);
      default:                  prdata = 32'd0;
    endcase
  end

  gti_front #(
    .MAX_SPAN (MAX_SPAN)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_load_index (in_load_index),
    .in_load_value (in_load_value),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_point_z    (in_point_z),
    .q_push        (q_push),
    .q_entry       (push_entry),
    .q_full        (q_full)
  );

  gti_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  gti_back #(
    .GRID_WORDS (GRID_WORDS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_entry          (pop_entry),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_used_nearest (out_used_nearest)
  );

endmodule
